FILE: src/hiat_pkg.sv
package hiat_pkg;

  // defaults for the curve geometry
  localparam int DIMS_DEF = 4;
  localparam int BITS_DEF = 4;

  // fixed field widths of the request and result transactions
  localparam int IDX_W      = 16;
  localparam int AXIS_W     = 4;
  localparam int NUM_FIELDS = 4;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [IDX_W-1:0]  curve_index;
    logic [AXIS_W-1:0] axis_in_0;
    logic [AXIS_W-1:0] axis_in_1;
    logic [AXIS_W-1:0] axis_in_2;
    logic [AXIS_W-1:0] axis_in_3;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index_out;
    logic [AXIS_W-1:0] axis_out_0;
    logic [AXIS_W-1:0] axis_out_1;
    logic [AXIS_W-1:0] axis_out_2;
    logic [AXIS_W-1:0] axis_out_3;
  } res_t;

endpackage

FILE: src/hilbert_index_axes_transform.sv
// Channel   | Ports                  | Handshake
// ----------+------------------------+-----------------------------------
// request   | start, busy, in_data   | taken when start && !busy
// result    | out_valid, out_data    | one-cycle strobe, cannot be held off
//
// One transaction per cycle, every cycle; busy is always low.
// Path: request register, then one combinational pass through
// the encoder or decoder into the result register.
// Reset (rst_n, synchronous) clears the valid bits only; no state is kept.
// Results must be taken when out_valid is high; the receiver cannot stall.
module hilbert_index_axes_transform #(
  parameter int DIMS = hiat_pkg::DIMS_DEF,
  parameter int BITS = hiat_pkg::BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  hiat_pkg::req_t  in_data,
  output logic            out_valid,
  output hiat_pkg::res_t  out_data
);

  localparam int IDXW   = DIMS * BITS;
  localparam int IEXT_W = (IDXW > hiat_pkg::IDX_W) ? IDXW : hiat_pkg::IDX_W;
  localparam int AEXT_W = (BITS > hiat_pkg::AXIS_W) ? BITS : hiat_pkg::AXIS_W;

  logic            in_vld_r;
  hiat_pkg::req_t  req_r;
  logic            out_valid_r;
  hiat_pkg::res_t  res_r;
  hiat_pkg::res_t  res_nxt;

  logic [hiat_pkg::AXIS_W-1:0] fld_in  [hiat_pkg::NUM_FIELDS];
  logic [hiat_pkg::AXIS_W-1:0] fld_out [hiat_pkg::NUM_FIELDS];
  logic [DIMS-1:0][BITS-1:0]   dec_axes;
  logic [DIMS-1:0][BITS-1:0]   enc_axes;
  logic [IDXW-1:0]             enc_idx;
  logic [IDXW-1:0]             dec_idx;
  logic [IEXT_W-1:0]           idx_in_ext;
  logic [IEXT_W-1:0]           idx_out_ext;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_data;
    end
  end

  assign fld_in[0] = req_r.axis_in_0;
  assign fld_in[1] = req_r.axis_in_1;
  assign fld_in[2] = req_r.axis_in_2;
  assign fld_in[3] = req_r.axis_in_3;

  // axes beyond the four fields read as zero
  always_comb begin
    logic [AEXT_W-1:0] ext;
    for (int i = 0; i < DIMS; i++) begin
      if (i < hiat_pkg::NUM_FIELDS) begin
        ext = AEXT_W'(fld_in[i]);
      end else begin
        ext = '0;
      end
      dec_axes[i] = ext[BITS-1:0];
    end
  end

  assign idx_in_ext = IEXT_W'(req_r.curve_index);
  assign enc_idx    = idx_in_ext[IDXW-1:0];

  hiat_encode #(.DIMS(DIMS), .BITS(BITS)) u_encode (
    .idx  (enc_idx),
    .axes (enc_axes)
  );

  hiat_decode #(.DIMS(DIMS), .BITS(BITS)) u_decode (
    .axes (dec_axes),
    .idx  (dec_idx)
  );

  assign idx_out_ext = IEXT_W'(dec_idx);

  always_comb begin
    logic [AEXT_W-1:0] ext;
    for (int i = 0; i < hiat_pkg::NUM_FIELDS; i++) begin
      if (i < DIMS) begin
        ext = AEXT_W'(enc_axes[i]);
      end else begin
        ext = '0;
      end
      fld_out[i] = ext[hiat_pkg::AXIS_W-1:0];
    end
  end

  always_comb begin
    res_nxt = '0;
    unique case (req_r.req_type)
      hiat_pkg::REQ_DECODE: begin
        res_nxt.index_out = idx_out_ext[hiat_pkg::IDX_W-1:0];
      end
      hiat_pkg::REQ_ENCODE: begin
        res_nxt.axis_out_0 = fld_out[0];
        res_nxt.axis_out_1 = fld_out[1];
        res_nxt.axis_out_2 = fld_out[2];
        res_nxt.axis_out_3 = fld_out[3];
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // every accepted transaction yields a strobe after the request and result registers
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid_r)
    else $error("accepted transaction produced no result strobe");

  // a result never carries both an index and axes
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.index_out == '0) ||
                    ((res_r.axis_out_0 == '0) && (res_r.axis_out_1 == '0) &&
                     (res_r.axis_out_2 == '0) && (res_r.axis_out_3 == '0)))
    else $error("result holds both index and axes");

  // an encode result has a zero index
  a_encode_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && (req_r.req_type == hiat_pkg::REQ_ENCODE)) |=>
      (out_valid_r && (res_r.index_out == '0)))
    else $error("encode result has nonzero index");

  // strobe only after a registered request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_valid_r |-> $past(in_vld_r))
    else $error("result strobe without a request");

endmodule

FILE: src/hiat_encode.sv
// Hilbert index to axes: de-interleave into transpose form, undo Gray code,
// then undo the per-level exchanges and reflections.
module hiat_encode #(
  parameter int DIMS = hiat_pkg::DIMS_DEF,
  parameter int BITS = hiat_pkg::BITS_DEF
) (
  input  logic [DIMS*BITS-1:0]       idx,
  output logic [DIMS-1:0][BITS-1:0]  axes
);

  always_comb begin
    logic [BITS-1:0] w [DIMS];
    logic [BITS-1:0] t;
    logic [BITS-1:0] p;
    for (int i = 0; i < DIMS; i++) begin
      for (int b = 0; b < BITS; b++) begin
        w[i][b] = idx[b*DIMS + DIMS - 1 - i];
      end
    end
    t = w[DIMS-1] >> 1;
    for (int i = DIMS - 1; i > 0; i--) begin
      w[i] = w[i] ^ w[i-1];
    end
    w[0] = w[0] ^ t;
    for (int j = 1; j < BITS; j++) begin
      p = {BITS{1'b1}} >> (BITS - j);
      for (int i = DIMS - 1; i >= 0; i--) begin
        if (w[i][j]) begin
          w[0] = w[0] ^ p;
        end else begin
          t    = (w[0] ^ w[i]) & p;
          w[0] = w[0] ^ t;
          w[i] = w[i] ^ t;
        end
      end
    end
    for (int i = 0; i < DIMS; i++) begin
      axes[i] = w[i];
    end
  end

endmodule

FILE: src/hiat_decode.sv
// Axes to Hilbert index: per-level exchanges and reflections, Gray code,
// then re-interleave the transpose words.
module hiat_decode #(
  parameter int DIMS = hiat_pkg::DIMS_DEF,
  parameter int BITS = hiat_pkg::BITS_DEF
) (
  input  logic [DIMS-1:0][BITS-1:0]  axes,
  output logic [DIMS*BITS-1:0]       idx
);

  always_comb begin
    logic [BITS-1:0] w [DIMS];
    logic [BITS-1:0] t;
    logic [BITS-1:0] p;
    for (int i = 0; i < DIMS; i++) begin
      w[i] = axes[i];
    end
    for (int j = BITS - 1; j > 0; j--) begin
      p = {BITS{1'b1}} >> (BITS - j);
      for (int i = 0; i < DIMS; i++) begin
        if (w[i][j]) begin
          w[0] = w[0] ^ p;
        end else begin
          t    = (w[0] ^ w[i]) & p;
          w[0] = w[0] ^ t;
          w[i] = w[i] ^ t;
        end
      end
    end
    for (int i = 1; i < DIMS; i++) begin
      w[i] = w[i] ^ w[i-1];
    end
    t = '0;
    for (int j = BITS - 1; j > 0; j--) begin
      p = {BITS{1'b1}} >> (BITS - j);
      if (w[DIMS-1][j]) begin
        t = t ^ p;
      end
    end
    for (int i = 0; i < DIMS; i++) begin
      w[i] = w[i] ^ t;
    end
    idx = '0;
    for (int i = 0; i < DIMS; i++) begin
      for (int b = 0; b < BITS; b++) begin
        idx[b*DIMS + DIMS - 1 - i] = w[i][b];
      end
    end
  end

endmodule
